### rtl/adam_pkg.sv
// adam_pkg: shared widths, register indexes and cell state types for the
// adam optimizer update unit. No dependencies.
package adam_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_BETA_FIRST        = 3'd0;
  localparam logic [2:0] REG_BETA_SECOND       = 3'd1;
  localparam logic [2:0] REG_BETA_FIRST_POWER  = 3'd2;
  localparam logic [2:0] REG_BETA_SECOND_POWER = 3'd3;
  localparam logic [2:0] REG_STEP_SIZE         = 3'd4;
  localparam logic [2:0] REG_DENOMINATOR_FLOOR = 3'd5;

  localparam int CFG_W = 24;

  // long division cell row: numerator, divisor widths
  localparam int DIV_N = 56;
  localparam int DIV_D = 41;

  // square root cell row: radicand, root, partial remainder widths
  localparam int SQ_X   = 64;
  localparam int SQ_R   = 32;
  localparam int SQ_REM = 35;

  typedef struct packed {
    logic [DIV_D-1:0] rem;
    logic [DIV_N-1:0] num;
    logic [DIV_N-1:0] quo;
    logic [DIV_D-1:0] den;
  } div_st_t;

  typedef struct packed {
    logic [SQ_REM-1:0] rem;
    logic [SQ_X-1:0]   x;
    logic [SQ_R-1:0]   root;
  } sq_st_t;

  // element data riding beside the arithmetic cells
  typedef struct packed {
    logic [31:0] w;
    logic [31:0] m_new;
    logic [30:0] v_new;
    logic        last;
    logic        neg;
  } side_t;

endpackage

### rtl/adam_div_cell.sv
// adam_div_cell: one restoring long-division step, one quotient bit per cell.
// Depends on adam_pkg.
module adam_div_cell (
  input  logic             clk,
  input  logic             en,
  input  adam_pkg::div_st_t st_i,
  output adam_pkg::div_st_t st_o
);
  import adam_pkg::*;

  div_st_t          st_r;
  div_st_t          st_nxt;
  logic [DIV_D:0]   trial;
  logic [DIV_D:0]   diff;
  logic             ge;

  // shift in the next numerator bit and try the divisor
  always_comb begin
    trial          = {st_i.rem, st_i.num[DIV_N-1]};
    diff           = trial - {1'b0, st_i.den};
    ge             = (trial >= {1'b0, st_i.den});
    st_nxt.rem     = ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
    st_nxt.num     = {st_i.num[DIV_N-2:0], 1'b0};
    st_nxt.quo     = {st_i.quo[DIV_N-2:0], ge};
    st_nxt.den     = st_i.den;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

### rtl/adam_sqrt_cell.sv
// adam_sqrt_cell: one digit-by-digit integer square root step, one root bit
// per cell. Depends on adam_pkg.
module adam_sqrt_cell (
  input  logic            clk,
  input  logic            en,
  input  adam_pkg::sq_st_t st_i,
  output adam_pkg::sq_st_t st_o
);
  import adam_pkg::*;

  sq_st_t            st_r;
  sq_st_t            st_nxt;
  logic [SQ_REM+1:0] trial;
  logic [SQ_REM+1:0] t;
  logic [SQ_REM+1:0] diff;
  logic              ge;

  // bring down two radicand bits, try root*4+1
  always_comb begin
    trial       = {st_i.rem, st_i.x[SQ_X-1:SQ_X-2]};
    t           = (SQ_REM+2)'({st_i.root, 2'b01});
    diff        = trial - t;
    ge          = (trial >= t);
    st_nxt.rem  = ge ? diff[SQ_REM-1:0] : trial[SQ_REM-1:0];
    st_nxt.x    = {st_i.x[SQ_X-3:0], 2'b00};
    st_nxt.root = {st_i.root[SQ_R-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

### rtl/adam_optimizer_update_unit.sv
// adam_optimizer_update_unit: top level of the fixed-point adam step.
// Depends on adam_pkg, adam_div_cell and adam_sqrt_cell.
//
// Usage:
// - in_* carries one parameter element per request: gradient, weight,
//   first and second moment (Q16.16), in_tlast marks the last element.
// - out_* returns the updated weight and moments with the copied tlast,
//   exactly one result per input, in input order.
// - cfg_* writes the decay, bias power, step size and epsilon registers;
//   write them only while no element is in flight.
// - A request passes through the moment math stages a, b and c, two
//   parallel 56-cell bias-correction division rows, a saturation stage,
//   a 32-cell square root row, a denominator stage and a 56-cell
//   division row for the update, each cell resolving one bit, and
//   then the output register. Every cell row is fully pipelined.
// - Throughput is one element per cycle unless the output stalls.
// - When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_tready drops; it resumes the cycle out_tready returns.
// - Reset empties the pipeline and loads the default register values.
module adam_optimizer_update_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // gradient[31:0], weight_in[63:32], moment_first_in[95:64],
  // moment_second_in[126:96], zero pad [127]
  input  logic [127:0]             in_tdata,
  input  logic                     in_tlast,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // weight_out[31:0], moment_first_out[63:32], moment_second_out[94:64],
  // zero pad [95]
  output logic [95:0]              out_tdata,
  output logic                     out_tlast,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_addr,
  input  logic [adam_pkg::CFG_W-1:0] cfg_wdata
);
  import adam_pkg::*;

  localparam int ST_D     = 3 + DIV_N;
  localparam int ST_F     = ST_D + 1 + SQ_R;
  localparam int ST_OUT   = ST_F + 1 + DIV_N;
  localparam int DEPTH    = ST_OUT + 1;

  // configuration registers
  logic [15:0] beta1_r, beta2_r, beta1p_r, beta2p_r;
  logic [23:0] step_r;
  logic [16:0] eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta1_r  <= 16'd58982;
      beta2_r  <= 16'd65470;
      beta1p_r <= 16'd58982;
      beta2p_r <= 16'd65470;
      step_r   <= 24'd16777;
      eps_r    <= 17'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BETA_FIRST:        beta1_r  <= cfg_wdata[15:0];
        REG_BETA_SECOND:       beta2_r  <= cfg_wdata[15:0];
        REG_BETA_FIRST_POWER:  beta1p_r <= cfg_wdata[15:0];
        REG_BETA_SECOND_POWER: beta2p_r <= cfg_wdata[15:0];
        REG_STEP_SIZE:         step_r   <= cfg_wdata[23:0];
        REG_DENOMINATOR_FLOOR: eps_r    <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  // pipeline advance and valid chain
  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic             adv;

  assign adv       = !vld_r[ST_OUT] || out_tready;
  assign in_tready = adv;
  assign vld_nxt   = {vld_r[DEPTH-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // stage a: products of the moment averages
  logic signed [31:0] g_in, m_in;
  logic        [31:0] ag;
  logic signed [48:0] pm1_r;
  logic signed [49:0] pm2_r;
  logic        [63:0] pgg_r;
  logic        [46:0] pv_r;
  logic        [31:0] wa_r;
  logic               lasta_r;

  assign g_in = $signed(in_tdata[31:0]);
  assign m_in = $signed(in_tdata[95:64]);
  assign ag   = g_in[31] ? (32'd0 - in_tdata[31:0]) : in_tdata[31:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      pm1_r   <= $signed({1'b0, beta1_r}) * m_in;
      pm2_r   <= $signed({1'b0, 17'(17'h10000 - {1'b0, beta1_r})}) * g_in;
      pgg_r   <= ag * ag;
      pv_r    <= beta2_r * in_tdata[126:96];
      wa_r    <= in_tdata[63:32];
      lasta_r <= in_tlast;
    end
  end

  // stage b: first moment with rounding and saturation
  logic signed [50:0] macc;
  logic signed [34:0] msh;
  logic        [31:0] mnew;
  logic        [31:0] mb_r, amb_r, wb_r;
  logic        [47:0] g2b_r;
  logic        [46:0] pvb_r;
  logic               negb_r, lastb_r;

  always_comb begin
    macc = 51'(pm1_r) + 51'(pm2_r) + 51'sd32768;
    msh  = 35'(macc >>> 16);
    if (msh > 35'sd2147483647) begin
      mnew = 32'h7FFF_FFFF;
    end else if (msh < -35'sd2147483648) begin
      mnew = 32'h8000_0000;
    end else begin
      mnew = msh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mb_r    <= mnew;
      negb_r  <= mnew[31];
      amb_r   <= mnew[31] ? (32'd0 - mnew) : mnew;
      g2b_r   <= pgg_r[63:16];
      pvb_r   <= pv_r;
      wb_r    <= wa_r;
      lastb_r <= lasta_r;
    end
  end

  // stage c: second moment with rounding and saturation
  logic [64:0] pv2;
  logic [65:0] vacc;
  logic [49:0] vsh;
  logic [30:0] vnew;
  logic [31:0] amc_r;
  side_t       sc_r;

  always_comb begin
    pv2  = {1'b0, 17'(17'h10000 - {1'b0, beta2_r})} * {17'd0, g2b_r};
    vacc = 66'(pvb_r) + 66'(pv2) + 66'd32768;
    vsh  = vacc[65:16];
    vnew = (vsh > 50'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : vsh[30:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      amc_r      <= amb_r;
      sc_r.w     <= wb_r;
      sc_r.m_new <= mb_r;
      sc_r.v_new <= vnew;
      sc_r.last  <= lastb_r;
      sc_r.neg   <= negb_r;
    end
  end

  // bias correction division rows
  div_st_t d1_st [DIV_N+1];
  div_st_t d2_st [DIV_N+1];
  side_t   s1_r  [DIV_N];

  assign d1_st[0] = '{rem: '0, num: {8'd0, amc_r, 16'd0}, quo: '0,
                      den: DIV_D'(17'h10000 - {1'b0, beta1p_r})};
  assign d2_st[0] = '{rem: '0, num: {9'd0, sc_r.v_new, 16'd0}, quo: '0,
                      den: DIV_D'(17'h10000 - {1'b0, beta2p_r})};

  for (genvar i = 0; i < DIV_N; i++) begin : g_bias_div
    adam_div_cell u_d1 (.clk(clk), .en(adv), .st_i(d1_st[i]), .st_o(d1_st[i+1]));
    adam_div_cell u_d2 (.clk(clk), .en(adv), .st_i(d2_st[i]), .st_o(d2_st[i+1]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r[0] <= sc_r;
      for (int i = 1; i < DIV_N; i++) begin
        s1_r[i] <= s1_r[i-1];
      end
    end
  end

  // stage d: saturate corrected first moment, form radicand
  logic [DIV_N-1:0] q1, cap;
  logic [31:0]      mhd_r;
  logic [SQ_X-1:0]  xd_r;
  side_t            sd_r;

  assign q1  = d1_st[DIV_N].quo;
  assign cap = s1_r[DIV_N-1].neg ? DIV_N'(33'h0_8000_0000) : DIV_N'(33'h0_7FFF_FFFF);

  always_ff @(posedge clk) begin
    if (adv) begin
      mhd_r <= (q1 > cap) ? cap[31:0] : q1[31:0];
      xd_r  <= {1'b0, d2_st[DIV_N].quo[46:0], 16'd0};
      sd_r  <= s1_r[DIV_N-1];
    end
  end

  // square root row
  sq_st_t      q_st [SQ_R+1];
  side_t       s2_r [SQ_R];
  logic [31:0] mh2_r [SQ_R];

  assign q_st[0] = '{rem: '0, x: xd_r, root: '0};

  for (genvar i = 0; i < SQ_R; i++) begin : g_root
    adam_sqrt_cell u_sq (.clk(clk), .en(adv), .st_i(q_st[i]), .st_o(q_st[i+1]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r[0]  <= sd_r;
      mh2_r[0] <= mhd_r;
      for (int i = 1; i < SQ_R; i++) begin
        s2_r[i]  <= s2_r[i-1];
        mh2_r[i] <= mh2_r[i-1];
      end
    end
  end

  // stage f: denominator and step product
  logic [32:0] den_r;
  logic [55:0] prod_r;
  side_t       sf_r;
  logic [16:0] eps;

  assign eps = (eps_r == 17'd0) ? 17'd1 : eps_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r  <= 33'(q_st[SQ_R].root) + 33'(eps);
      prod_r <= step_r * mh2_r[SQ_R-1];
      sf_r   <= s2_r[SQ_R-1];
    end
  end

  // update division row
  div_st_t d3_st [DIV_N+1];
  side_t   s3_r  [DIV_N];

  assign d3_st[0] = '{rem: '0, num: prod_r, quo: '0, den: {den_r, 8'd0}};

  for (genvar i = 0; i < DIV_N; i++) begin : g_upd_div
    adam_div_cell u_d3 (.clk(clk), .en(adv), .st_i(d3_st[i]), .st_o(d3_st[i+1]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r[0] <= sf_r;
      for (int i = 1; i < DIV_N; i++) begin
        s3_r[i] <= s3_r[i-1];
      end
    end
  end

  // output register: apply update with saturation
  side_t              sl;
  logic signed [57:0] wsum;
  logic        [31:0] wnew;
  logic        [31:0] wo_r, mo_r;
  logic        [30:0] vo_r;
  logic               lo_r;

  assign sl = s3_r[DIV_N-1];

  always_comb begin
    if (sl.neg) begin
      wsum = 58'($signed(sl.w)) + $signed({2'b00, d3_st[DIV_N].quo});
    end else begin
      wsum = 58'($signed(sl.w)) - $signed({2'b00, d3_st[DIV_N].quo});
    end
    if (wsum > 58'sd2147483647) begin
      wnew = 32'h7FFF_FFFF;
    end else if (wsum < -58'sd2147483648) begin
      wnew = 32'h8000_0000;
    end else begin
      wnew = wsum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wo_r <= wnew;
      mo_r <= sl.m_new;
      vo_r <= sl.v_new;
      lo_r <= sl.last;
    end
  end

  assign out_tvalid = vld_r[ST_OUT];
  assign out_tdata  = {1'b0, vo_r, mo_r, wo_r};
  assign out_tlast  = lo_r;

  // checks
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(vld_r))
    else $error("pipeline moved during output stall");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_F] |-> (den_r != 33'd0))
    else $error("update denominator is zero");

  a_mh_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[ST_D] && !sd_r.neg) |-> !mhd_r[31])
    else $error("positive corrected moment above cap");

endmodule
